@@ rtl/ep0ds_pkg.sv @@
// Shared types and constants for the endpoint 0 data-stage sequencer.
package ep0ds_pkg;

  localparam int LEN_W   = 16;
  localparam int CNT_W   = 7;
  localparam int SIZE_W  = 7;
  localparam int MODE_W  = 3;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    EV_SETUP     = 3'd0,
    EV_START_IN  = 3'd1,
    EV_IN_DONE   = 3'd2,
    EV_START_OUT = 3'd3,
    EV_OUT_PKT   = 3'd4,
    EV_ZLP       = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    PH_NOTHING  = 2'd0,
    PH_DATA_IN  = 2'd1,
    PH_DATA_OUT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] in_remaining;
    logic             in_active;
    logic             host_wants_more;
    logic [LEN_W-1:0] out_remaining;
    phase_t           status_phase;
  } ep_state_t;

  // Packed so that load_in lands in bit 0 of the result word.
  typedef struct packed {
    logic [1:0]        pad;
    phase_t            phase;
    logic              nak_both;
    logic              accept_out;
    logic              stall_out;
    logic              stall_in;
    logic [SIZE_W-1:0] in_size;
    logic              load_in;
  } ep_result_t;

endpackage

@@ rtl/usb_ep0_data_stage_sequencer_top.sv @@
// Endpoint 0 data-stage sequencer: event stream in, endpoint control stream out.
//
// Each request on the slave channel is one control-endpoint event, its kind in
// s_tuser. The block updates the IN/OUT byte counters and the status phase and
// emits one result on the master channel: IN packet size to load, stall and
// accept strobes, NAK on setup, and the resulting phase.
// One request is accepted per cycle while s_tready is high; the event logic
// sits between the request and a two-entry output register, so one more
// request is taken while a result waits. s_tready drops only when both
// output slots are full.
// MAX_PACKET is the endpoint 0 maximum packet size (8 to 64 bytes).
// Reset clears the counters, the pending-IN and host-wants-more flags, the
// phase and both output slots. When the receiver stalls, the front result
// holds on m_tdata until m_tready.
module usb_ep0_data_stage_sequencer_top
  import ep0ds_pkg::*;
#(
  parameter int MAX_PACKET = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] request_length, [31:16] available_length, [38:32] out_byte_count
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] mode
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] load_in, [7:1] in_size, [8] stall_in, [9] stall_out, [10] accept_out,
  // [11] nak_both, [13:12] phase
  output logic [OUT_DATA_W-1:0] m_tdata
);

  ep_state_t  state;
  ep_state_t  state_next;
  ep_result_t result;
  logic       accept;

  assign accept = s_tvalid && s_tready;

  ep0ds_step #(
    .MAX_PACKET(MAX_PACKET)
  ) u_step (
    .mode             (s_tuser),
    .request_length   (s_tdata[15:0]),
    .available_length (s_tdata[31:16]),
    .out_byte_count   (s_tdata[38:32]),
    .state            (state),
    .state_next       (state_next),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{in_remaining: '0, in_active: 1'b0, host_wants_more: 1'b0,
                 out_remaining: '0, status_phase: PH_NOTHING};
    end else if (accept) begin
      state <= state_next;
    end
  end

  ep0ds_skid #(
    .WIDTH(OUT_DATA_W)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .space     (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ rtl/ep0ds_step.sv @@
// Next-state and result logic for one sequencer event.
module ep0ds_step
  import ep0ds_pkg::*;
#(
  parameter int MAX_PACKET = 8
) (
  input  logic [MODE_W-1:0] mode,
  input  logic [LEN_W-1:0]  request_length,
  input  logic [LEN_W-1:0]  available_length,
  input  logic [CNT_W-1:0]  out_byte_count,
  input  ep_state_t         state,
  output ep_state_t         state_next,
  output ep_result_t        result
);

  localparam logic [LEN_W-1:0]  MP_LEN  = LEN_W'(MAX_PACKET);
  localparam logic [SIZE_W-1:0] MP_SIZE = SIZE_W'(MAX_PACKET);

  ep_state_t        snd_in;
  ep_state_t        snd_out;
  ep_result_t       snd_res;
  logic [LEN_W-1:0] out_left;

  // Source state for a send: a new reply on start in, the held one on in done.
  always_comb begin
    snd_in = state;
    if (mode == EV_START_IN) begin
      if (available_length >= request_length) begin
        snd_in.in_remaining    = request_length;
        snd_in.host_wants_more = 1'b0;
      end else begin
        snd_in.in_remaining    = available_length;
        snd_in.host_wants_more = 1'b1;
      end
      snd_in.in_active = 1'b1;
    end
  end

  always_comb begin
    snd_out = snd_in;
    snd_res = '0;
    if (!snd_in.in_active) begin
      snd_out.status_phase = PH_NOTHING;
    end else begin
      snd_res.load_in = 1'b1;
      if (snd_in.in_remaining > MP_LEN) begin
        snd_res.in_size      = MP_SIZE;
        snd_out.in_remaining = snd_in.in_remaining - MP_LEN;
        snd_out.status_phase = PH_DATA_IN;
      end else if (snd_in.in_remaining < MP_LEN) begin
        snd_res.in_size      = snd_in.in_remaining[SIZE_W-1:0];
        snd_out.in_remaining = '0;
        snd_out.in_active    = 1'b0;
        snd_out.status_phase = PH_NOTHING;
      end else begin
        // Exact boundary: a zero-length packet is still owed if the host wants more.
        snd_res.in_size      = MP_SIZE;
        snd_out.in_remaining = '0;
        if (snd_in.host_wants_more) begin
          snd_out.status_phase = PH_DATA_IN;
        end else begin
          snd_out.in_active    = 1'b0;
          snd_out.status_phase = PH_NOTHING;
        end
      end
    end
  end

  assign out_left = state.out_remaining - LEN_W'(out_byte_count);

  always_comb begin
    state_next = state;
    result     = '0;
    unique case (mode)
      EV_SETUP: begin
        result.nak_both         = 1'b1;
        state_next.status_phase = PH_NOTHING;
      end
      EV_START_IN: begin
        state_next = snd_out;
        result     = snd_res;
      end
      EV_IN_DONE: begin
        if (state.status_phase == PH_DATA_IN) begin
          state_next = snd_out;
          result     = snd_res;
        end else begin
          result.stall_in = 1'b1;
        end
      end
      EV_START_OUT: begin
        state_next.out_remaining = request_length;
        state_next.status_phase  = PH_DATA_OUT;
      end
      EV_OUT_PKT: begin
        if (state.status_phase != PH_DATA_OUT) begin
          result.stall_out = 1'b1;
        end else if (state.out_remaining >= LEN_W'(out_byte_count)) begin
          result.accept_out        = 1'b1;
          state_next.out_remaining = out_left;
          if (out_left == '0) begin
            // Last expected bytes end the data stage.
            result.stall_out        = 1'b1;
            state_next.status_phase = PH_NOTHING;
          end
        end else begin
          result.stall_out        = 1'b1;
          state_next.status_phase = PH_NOTHING;
        end
      end
      EV_ZLP: begin
        state_next.in_active    = 1'b0;
        state_next.status_phase = PH_NOTHING;
        result.load_in          = 1'b1;
      end
      default: begin
      end
    endcase
    result.phase = state_next.status_phase;
  end

endmodule

@@ rtl/ep0ds_skid.sv @@
// Two-entry output register with skid slot for the result stream.
module ep0ds_skid #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [WIDTH-1:0] m_tdata
);

  logic             out_valid;
  logic [WIDTH-1:0] out_data;
  logic             skid_valid;
  logic [WIDTH-1:0] skid_data;
  logic             pop;

  assign pop      = out_valid && m_tready;
  assign space    = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

@@ rtl/ep0ds_checker.sv @@
// Port-level checks for the endpoint 0 data-stage sequencer.
module ep0ds_checker
  import ep0ds_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_setup_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> m_tdata[13:12] == PH_NOTHING && m_tdata[10:0] == '0)
    else $error("setup result carries other actions");

  a_size_needs_load: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:1] != '0 |-> m_tdata[0] && !m_tdata[8] && !m_tdata[10])
    else $error("IN size without load");

  a_accept_phase: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> !m_tdata[0] &&
      (m_tdata[13:12] == PH_DATA_OUT || (m_tdata[13:12] == PH_NOTHING && m_tdata[9])))
    else $error("OUT accept with inconsistent phase");

endmodule

bind usb_ep0_data_stage_sequencer_top ep0ds_checker u_ep0ds_checker (.*);

@@ tb/ep0ds_result_checker.sv @@
// Scoreboard for the endpoint 0 data-stage sequencer: predicts and checks every result.
module ep0ds_result_checker
  import ep0ds_pkg::*;
#(
  parameter int MAX_PACKET = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [MODE_W-1:0]     s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    fail_count,
  output int                    results_pending
);

  logic [LEN_W-1:0] in_left;
  logic             in_busy;
  logic             host_more;
  logic [LEN_W-1:0] out_left;
  phase_t           ctl_phase;
  ep_result_t       expected_q[$];
  int               mismatches = 0;

  // Load the next IN packet size, or end the reply when nothing is pending.
  function automatic void load_next_packet(inout ep_result_t r);
    logic [LEN_W-1:0] size;
    if (!in_busy) begin
      ctl_phase = PH_NOTHING;
      return;
    end
    if (in_left > MAX_PACKET) begin
      size = LEN_W'(MAX_PACKET);
      in_left = in_left - LEN_W'(MAX_PACKET);
      ctl_phase = PH_DATA_IN;
    end else if (in_left < MAX_PACKET) begin
      size = in_left;
      in_left = '0;
      in_busy = 1'b0;
      ctl_phase = PH_NOTHING;
    end else begin
      // exact boundary: a zero-length packet is still due if the host wants more
      size = LEN_W'(MAX_PACKET);
      in_left = '0;
      if (host_more) begin
        ctl_phase = PH_DATA_IN;
      end else begin
        in_busy = 1'b0;
        ctl_phase = PH_NOTHING;
      end
    end
    r.load_in = 1'b1;
    r.in_size = size[SIZE_W-1:0];
  endfunction

  function automatic ep_result_t sequence_event(logic [MODE_W-1:0] mode,
                                                logic [LEN_W-1:0] req,
                                                logic [LEN_W-1:0] avail,
                                                logic [CNT_W-1:0] cnt);
    ep_result_t r;
    r = '0;
    case (mode)
      EV_SETUP: begin
        r.nak_both = 1'b1;
        ctl_phase = PH_NOTHING;
      end
      EV_START_IN: begin
        if (avail >= req) begin
          in_left = req;
          host_more = 1'b0;
        end else begin
          in_left = avail;
          host_more = 1'b1;
        end
        in_busy = 1'b1;
        load_next_packet(r);
      end
      EV_IN_DONE: begin
        if (ctl_phase == PH_DATA_IN) load_next_packet(r);
        else r.stall_in = 1'b1;
      end
      EV_START_OUT: begin
        out_left = req;
        ctl_phase = PH_DATA_OUT;
      end
      EV_OUT_PKT: begin
        if (ctl_phase != PH_DATA_OUT) begin
          r.stall_out = 1'b1;
        end else if (out_left >= cnt) begin
          r.accept_out = 1'b1;
          out_left = out_left - cnt;
          // last expected bytes end the data stage
          if (out_left == '0) begin
            r.stall_out = 1'b1;
            ctl_phase = PH_NOTHING;
          end
        end else begin
          r.stall_out = 1'b1;
          ctl_phase = PH_NOTHING;
        end
      end
      EV_ZLP: begin
        in_busy = 1'b0;
        ctl_phase = PH_NOTHING;
        r.load_in = 1'b1;
        r.in_size = '0;
      end
      default: begin
      end
    endcase
    r.phase = ctl_phase;
    return r;
  endfunction

  always @(posedge clk) begin
    ep_result_t want;
    ep_result_t got;
    if (rst) begin
      in_left = '0;
      in_busy = 1'b0;
      host_more = 1'b0;
      out_left = '0;
      ctl_phase = PH_NOTHING;
      expected_q.delete();
    end else begin
      // retire the result first: it never belongs to a request taken at this edge
      if (m_tvalid && m_tready) begin
        got = ep_result_t'(m_tdata);
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request pending: %h", $time, m_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got.load_in !== want.load_in || got.in_size !== want.in_size ||
              got.stall_in !== want.stall_in || got.stall_out !== want.stall_out ||
              got.accept_out !== want.accept_out || got.nak_both !== want.nak_both ||
              got.phase !== want.phase) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch, expected load_in=%0d in_size=%0d stall_in=%0d",
                       $time, want.load_in, want.in_size, want.stall_in);
              $display("  stall_out=%0d accept_out=%0d nak_both=%0d phase=%0d",
                       want.stall_out, want.accept_out, want.nak_both, want.phase);
              $display("  got load_in=%0d in_size=%0d stall_in=%0d stall_out=%0d",
                       got.load_in, got.in_size, got.stall_in, got.stall_out);
              $display("  accept_out=%0d nak_both=%0d phase=%0d",
                       got.accept_out, got.nak_both, got.phase);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_q.push_back(sequence_event(s_tuser, s_tdata[15:0], s_tdata[31:16],
                                            s_tdata[38:32]));
    end
    results_pending <= expected_q.size();
    fail_count <= mismatches;
  end

endmodule

@@ tb/tb_usb_ep0_data_stage_sequencer_top.sv @@
// Testbench top for the endpoint 0 data-stage sequencer: stimulus, back-pressure and verdict.
module tb_usb_ep0_data_stage_sequencer_top;
  import ep0ds_pkg::*;

  localparam int MAX_PACKET  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_EVENTS = 700;
  localparam logic [MODE_W-1:0] EV_RSVD6 = 3'd6;
  localparam logic [MODE_W-1:0] EV_RSVD7 = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [MODE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int fail_count;
  int results_pending;
  int cycles = 0;
  int events_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_off_req = 1'b0;

  usb_ep0_data_stage_sequencer_top #(.MAX_PACKET(MAX_PACKET)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ep0ds_result_checker #(.MAX_PACKET(MAX_PACKET)) result_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Offer one request; returns at the edge where it was taken.
  task automatic send_event(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] req,
                            input logic [LEN_W-1:0] avail, input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {1'b0, cnt, avail, req};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    if (mode <= EV_ZLP) events_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  // Mostly short lengths, some full range, a few at the extremes.
  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return LEN_W'($urandom_range(0, 64));
    if (roll < 95) return LEN_W'($urandom_range(0, 65535));
    return ($urandom_range(1) != 0) ? '1 : '0;
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    if ($urandom_range(9) == 0) return CNT_W'($urandom_range(0, 127));
    return CNT_W'($urandom_range(0, MAX_PACKET));
  endfunction

  initial begin
    int roll;
    int reps;
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: stray packets after reset, then each IN and OUT ending
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    send_event(EV_OUT_PKT, 16'hFFFF, 16'hFFFF, 7'd127);
    send_event(EV_SETUP, 16'hFFFF, 16'hFFFF, 7'd127);
    send_event(EV_START_IN, 16'd20, 16'd100, 7'd0);
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    // short reply on a packet boundary: zero-length packet follows
    send_event(EV_START_IN, 16'd100, 16'd16, 7'd0);
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    send_event(EV_START_IN, 16'd16, 16'd16, 7'd0);
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    send_event(EV_START_IN, 16'd0, 16'd0, 7'd0);
    send_event(EV_ZLP, 16'd0, 16'd0, 7'd0);
    send_event(EV_START_OUT, 16'd20, 16'd0, 7'd0);
    send_event(EV_OUT_PKT, 16'd0, 16'd0, 7'd8);
    send_event(EV_OUT_PKT, 16'd0, 16'd0, 7'd127);
    send_event(EV_START_OUT, 16'd10, 16'd0, 7'd0);
    send_event(EV_OUT_PKT, 16'd0, 16'd0, 7'd10);
    send_event(EV_START_OUT, 16'hFFFF, 16'd0, 7'd0);
    send_event(EV_OUT_PKT, 16'd0, 16'd0, 7'd0);
    send_event(EV_START_IN, 16'hFFFF, 16'hFFFF, 7'd0);
    send_event(EV_SETUP, 16'd0, 16'd0, 7'd0);
    send_event(EV_IN_DONE, 16'd0, 16'd0, 7'd0);
    send_event(EV_RSVD6, 16'hFFFF, 16'hFFFF, 7'd127);
    send_event(EV_RSVD7, 16'd0, 16'd0, 7'd0);
    drain_results();

    events_sent = 0;
    while (events_sent < RANDOM_EVENTS) begin
      case ((events_sent / 80) % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      if (!hold_done && events_sent >= 250) begin
        hold_done = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!pause_done && events_sent >= 500) begin
        pause_done = 1'b1;
        drain_results();
      end

      roll = $urandom_range(99);
      if (roll < 45) begin
        // IN transfer: setup, reply start, packets done, usually a status packet
        if ($urandom_range(9) != 0)
          send_event(EV_SETUP, LEN_W'($urandom), LEN_W'($urandom), CNT_W'($urandom));
        send_event(EV_START_IN, pick_length(), pick_length(), CNT_W'($urandom));
        reps = $urandom_range(0, 12);
        repeat (reps)
          send_event(EV_IN_DONE, LEN_W'($urandom), LEN_W'($urandom), CNT_W'($urandom));
        if ($urandom_range(9) < 7)
          send_event(EV_ZLP, LEN_W'($urandom), LEN_W'($urandom), CNT_W'($urandom));
      end else if (roll < 80) begin
        // OUT transfer: setup, data stage start, a run of packets
        if ($urandom_range(9) != 0)
          send_event(EV_SETUP, LEN_W'($urandom), LEN_W'($urandom), CNT_W'($urandom));
        send_event(EV_START_OUT, pick_length(), LEN_W'($urandom), CNT_W'($urandom));
        reps = $urandom_range(1, 15);
        repeat (reps)
          send_event(EV_OUT_PKT, LEN_W'($urandom), LEN_W'($urandom), pick_count());
      end else begin
        send_event(MODE_W'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 65535)),
                   LEN_W'($urandom_range(0, 65535)), CNT_W'($urandom_range(0, 127)));
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/ep0ds_pkg.sv
rtl/ep0ds_step.sv
rtl/ep0ds_skid.sv
rtl/usb_ep0_data_stage_sequencer_top.sv
rtl/ep0ds_checker.sv
tb/ep0ds_result_checker.sv
tb/tb_usb_ep0_data_stage_sequencer_top.sv
